### hw/rtl/mbe_pkg.sv
// Shared types, constants and fixed-point helpers for the escape-time evaluator.
`timescale 1ns / 1ps
package mbe_pkg;

	localparam int COORD_WIDTH     = 32;
	localparam int FRACTION_BITS   = 28;
	localparam int PROD_WIDTH      = 2 * COORD_WIDTH;
	localparam int STEP_WIDTH      = 31;
	localparam int PIXEL_WIDTH     = 10;
	localparam int COUNT_WIDTH     = 12;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int ESCAPE_RADIUS   = 2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;

	localparam coord_t                   ORIGIN_RESET = -32'sd536870912;
	localparam logic [STEP_WIDTH-1:0]    STEP_RESET   = 31'd1048576;
	localparam logic [COUNT_WIDTH-1:0]   LIMIT_RESET  = 12'd1000;

	// Escape when |z|^2 reaches the squared radius, expressed in fixed point.
	localparam prod_t ESCAPE_BOUND = prod_t'(ESCAPE_RADIUS * ESCAPE_RADIUS) <<< FRACTION_BITS;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ORIGIN_REAL = 3'd0,
		REG_ORIGIN_IMAG = 3'd1,
		REG_STEP_REAL   = 3'd2,
		REG_STEP_IMAG   = 3'd3,
		REG_ITER_LIMIT  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		coord_t                  origin_real;
		coord_t                  origin_imag;
		logic [STEP_WIDTH-1:0]   step_real;
		logic [STEP_WIDTH-1:0]   step_imag;
		logic [COUNT_WIDTH-1:0]  iteration_limit;
	} cfg_t;

	// Sign-extend a coordinate to product width.
	function automatic prod_t widen(input coord_t x);
		return prod_t'(x);
	endfunction

	// Clamp a wide signed value into the coordinate range.
	function automatic coord_t sat_coord(input prod_t v);
		prod_t hi;
		prod_t lo;
		hi = {{(PROD_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			return hi[COORD_WIDTH-1:0];
		end
		if (v < lo) begin
			return lo[COORD_WIDTH-1:0];
		end
		return v[COORD_WIDTH-1:0];
	endfunction

	// Rescale an exact product: arithmetic shift rounds toward minus infinity.
	function automatic coord_t fx_scale(input prod_t p);
		prod_t q;
		q = p >>> FRACTION_BITS;
		return sat_coord(q);
	endfunction

endpackage

### hw/rtl/mandelbrot_escape_time.sv
// Top level of the escape-time evaluator: sequencer, datapath and result register.
`timescale 1ns / 1ps
//
// Channel        Signals                                   Direction  Transaction when
// -------------  ----------------------------------------  ---------  ----------------------------
// pixel command  start, busy, column, row                  in         start high and busy low
// result         done, escape_count, inside_res            out        done high (one cycle)
// configuration  cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid and cfg_ready high
//
// Each pixel forms its coordinate in CR/CI/CZ and then iterates until z escapes or the
// iteration limit is reached; the result is registered from the final test state.
// The iteration is serialised on the single 32x32 multiplier: every iteration needs three
// products (zr*zr, zi*zi, zr*zi), plus the UPD state for the z update and the TEST state
// for the escape and limit test.
// Reset is asynchronous and active low; it returns the configuration registers to defaults
// and the sequencer to idle. The result cannot be stalled: done is a one-cycle strobe, and a new
// pixel may be started in the same cycle that the previous result is presented.
// Configuration transactions are taken only while the block is idle.
module mandelbrot_escape_time (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [mbe_pkg::PIXEL_WIDTH-1:0]      column,
	input  logic [mbe_pkg::PIXEL_WIDTH-1:0]      row,
	output logic                                 done,
	output logic [mbe_pkg::COUNT_WIDTH-1:0]      escape_count,
	output logic                                 inside_res,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mbe_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [mbe_pkg::COORD_WIDTH-1:0]      cfg_data
);
	import mbe_pkg::*;

	// Sequencer states. The pixel coordinate is formed in CR/CI/CZ, then each iteration
	// runs UPD (new z), MRR/MII/MRI (issue the three products) and TEST.
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_CR   = 9'b000000010,
		ST_CI   = 9'b000000100,
		ST_CZ   = 9'b000001000,
		ST_UPD  = 9'b000010000,
		ST_MRR  = 9'b000100000,
		ST_MII  = 9'b001000000,
		ST_MRI  = 9'b010000000,
		ST_TEST = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	cfg_t cfg;

	logic [PIXEL_WIDTH-1:0] col_q;
	logic [PIXEL_WIDTH-1:0] row_q;
	coord_t cr_q;
	coord_t ci_q;
	coord_t zr_q;
	coord_t zi_q;
	coord_t rr_q;
	coord_t ii_q;
	coord_t ri_q;
	logic [COUNT_WIDTH-1:0] iter_q;

	logic                   done_q;
	logic [COUNT_WIDTH-1:0] escape_count_q;
	logic                   inside_res_q;

	coord_t mul_a;
	coord_t mul_b;
	prod_t  mul_p;

	logic   accept;
	logic   escaped;
	logic   at_limit;
	coord_t zr_next;
	coord_t zi_next;
	coord_t ri_double;

	assign busy      = !state_q[0];
	assign accept    = start && !busy;
	assign cfg_ready = !busy;

	mbe_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Operand selection for the shared multiplier; the product is registered and appears in the next cycle.
	always_comb begin
		mul_a = zr_q;
		mul_b = zr_q;
		unique case (state_q)
			ST_CR: begin
				mul_a = coord_t'(col_q);
				mul_b = coord_t'(cfg.step_real);
			end
			ST_CI: begin
				mul_a = coord_t'(row_q);
				mul_b = coord_t'(cfg.step_imag);
			end
			ST_MII: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			ST_MRI: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
			end
		endcase
	end

	mbe_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.product (mul_p)
	);

	// z update: real part rr - ii + cr, imaginary part 2*ri + ci, each step saturated.
	assign zr_next   = sat_coord(widen(rr_q) - widen(ii_q) + widen(cr_q));
	assign ri_double = sat_coord(widen(ri_q) <<< 1);
	assign zi_next   = sat_coord(widen(ri_double) + widen(ci_q));

	// The squares of the new z double as the magnitude; their sum is exact.
	assign escaped  = (widen(rr_q) + widen(ii_q)) >= ESCAPE_BOUND;
	assign at_limit = iter_q >= cfg.iteration_limit;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CR;
				end
			end
			ST_CR:   state_d = ST_CI;
			ST_CI:   state_d = ST_CZ;
			ST_CZ:   state_d = ST_UPD;
			ST_UPD:  state_d = ST_MRR;
			ST_MRR:  state_d = ST_MII;
			ST_MII:  state_d = ST_MRI;
			ST_MRI:  state_d = ST_TEST;
			ST_TEST: begin
				if (escaped || at_limit) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_UPD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_TEST) && (escaped || at_limit);
			if (accept) begin
				iter_q <= '0;
			end else if ((state_q == ST_TEST) && !escaped && !at_limit) begin
				iter_q <= iter_q + 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= column;
			row_q <= row;
			zr_q  <= '0;
			zi_q  <= '0;
			rr_q  <= '0;
			ii_q  <= '0;
			ri_q  <= '0;
		end
		unique case (state_q)
			ST_CI:   cr_q <= sat_coord(widen(cfg.origin_real) + mul_p);
			ST_CZ:   ci_q <= sat_coord(widen(cfg.origin_imag) + mul_p);
			ST_UPD: begin
				zr_q <= zr_next;
				zi_q <= zi_next;
			end
			ST_MII:  rr_q <= fx_scale(mul_p);
			ST_MRI:  ii_q <= fx_scale(mul_p);
			ST_TEST: ri_q <= fx_scale(mul_p);
			default: begin
			end
		endcase
		if (state_q == ST_TEST) begin
			// The escape test wins over the limit test.
			escape_count_q <= escaped ? iter_q : '0;
			inside_res_q   <= !escaped;
		end
	end

	assign done         = done_q;
	assign escape_count = escape_count_q;
	assign inside_res   = inside_res_q;

	// An accepted pixel always leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted pixel did not make the block busy");

	// One strobe per pixel: results are never back to back.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// A result follows the test state directly.
	a_done_after_test: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_TEST))
		else $error("result strobe without a finished test");

	// Inside points report a zero count.
	a_inside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && inside_res) |-> (escape_count == '0))
		else $error("inside result carries a nonzero count");

	// The iteration counter never runs past the limit while a pixel is in work.
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (iter_q <= cfg.iteration_limit))
		else $error("iteration counter exceeded the limit");

endmodule

### hw/rtl/mbe_mul.sv
// Shared signed multiplier with a registered full-width product.
`timescale 1ns / 1ps
module mbe_mul (
	input  logic           clk,
	input  mbe_pkg::coord_t a,
	input  mbe_pkg::coord_t b,
	output mbe_pkg::prod_t  product
);
	import mbe_pkg::*;

	prod_t product_q;
	prod_t product_d;

	assign product_d = prod_t'(a) * prod_t'(b);

	always_ff @(posedge clk) begin
		product_q <= product_d;
	end

	assign product = product_q;

endmodule

### hw/rtl/mbe_cfg.sv
// Configuration register file for the escape-time evaluator.
`timescale 1ns / 1ps
module mbe_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [mbe_pkg::CFG_INDEX_WIDTH-1:0]   wr_index,
	input  logic [mbe_pkg::COORD_WIDTH-1:0]       wr_data,
	output mbe_pkg::cfg_t                         cfg
);
	import mbe_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_real     <= ORIGIN_RESET;
			cfg_q.origin_imag     <= ORIGIN_RESET;
			cfg_q.step_real       <= STEP_RESET;
			cfg_q.step_imag       <= STEP_RESET;
			cfg_q.iteration_limit <= LIMIT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ORIGIN_REAL: cfg_q.origin_real     <= coord_t'(wr_data);
				REG_ORIGIN_IMAG: cfg_q.origin_imag     <= coord_t'(wr_data);
				REG_STEP_REAL:   cfg_q.step_real       <= wr_data[STEP_WIDTH-1:0];
				REG_STEP_IMAG:   cfg_q.step_imag       <= wr_data[STEP_WIDTH-1:0];
				REG_ITER_LIMIT:  cfg_q.iteration_limit <= wr_data[COUNT_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
